// ===== hdl/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 decoder unit: payload structs, the queue entry type and
// the code point limits shared by the front end, the queue and the back end.
// No dependencies.
package u8u16_pkg;

	// One raw byte of a UTF-8 string with its end-of-string flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_last;
	} in_item_t;

	// One UTF-16 result.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_error;
		logic        run_last;
		logic        string_end;
	} out_item_t;

	// Queue entry: either a validated code point or an error report.
	typedef struct packed {
		logic        is_error;
		logic        string_end;
		logic [20:0] point;
	} event_t;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
	localparam logic [20:0] SURR_FIRST     = 21'h00D800;
	localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
	localparam logic [20:0] BMP_LAST       = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE      = 21'h010000;
	localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
	localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
	localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

	// Sequence length classes.
	localparam logic [1:0] LEN_TWO   = 2'd1;
	localparam logic [1:0] LEN_THREE = 2'd2;
	localparam logic [1:0] LEN_FOUR  = 2'd3;

endpackage

// ===== hdl/u8u16_front.sv =====
// Front end of the UTF-8 to UTF-16 decoder unit: classifies each byte, gathers and
// validates code points and reports errors. Depends on u8u16_pkg.
module u8u16_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  u8u16_pkg::in_item_t item,
	output logic               ev_valid,
	output u8u16_pkg::event_t  ev
);
	import u8u16_pkg::*;

	logic [20:0] point_accum_q;
	logic [1:0]  bytes_remaining_q;
	logic [1:0]  length_class_q;
	logic        discarding_q;

	logic [20:0] point_nx;
	logic [1:0]  bytes_remaining_nx;
	logic [1:0]  length_class_nx;
	logic        discarding_nx;
	logic [20:0] joined;
	logic [1:0]  rem_dec;
	logic [20:0] minimum;
	logic        bad_point;
	logic        raise_error;
	logic        emit_point;
	logic [20:0] emit_value;
	logic [7:0]  b;
	logic        last;

	assign b       = item.data_byte;
	assign last    = item.string_last;
	assign joined  = {point_accum_q[14:0], b[5:0]};
	assign rem_dec = bytes_remaining_q - 2'd1;

	always_comb begin
		case (length_class_q)
			LEN_TWO:   minimum = MIN_TWO_BYTE;
			LEN_THREE: minimum = MIN_THREE_BYTE;
			default:   minimum = SUPP_BASE;
		endcase
	end

	assign bad_point = (joined < minimum) || (joined > MAX_POINT) ||
			((joined >= SURR_FIRST) && (joined <= SURR_LAST));

	always_comb begin
		point_nx           = point_accum_q;
		bytes_remaining_nx = bytes_remaining_q;
		length_class_nx    = length_class_q;
		discarding_nx      = discarding_q;
		raise_error        = 1'b0;
		emit_point         = 1'b0;
		emit_value         = {13'd0, b};
		if (discarding_q) begin
			if (last) begin
				discarding_nx      = 1'b0;
				point_nx           = '0;
				bytes_remaining_nx = '0;
				length_class_nx    = '0;
			end
		end else if (bytes_remaining_q == 2'd0) begin
			if (b[7] == 1'b0) begin
				emit_point = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				point_nx           = {16'd0, b[4:0]};
				bytes_remaining_nx = 2'd1;
				length_class_nx    = LEN_TWO;
				raise_error        = last;
			end else if (b[7:4] == 4'b1110) begin
				point_nx           = {17'd0, b[3:0]};
				bytes_remaining_nx = 2'd2;
				length_class_nx    = LEN_THREE;
				raise_error        = last;
			end else if (b[7:3] == 5'b11110) begin
				point_nx           = {18'd0, b[2:0]};
				bytes_remaining_nx = 2'd3;
				length_class_nx    = LEN_FOUR;
				raise_error        = last;
			end else begin
				raise_error = 1'b1;
			end
		end else if (b[7:6] != 2'b10) begin
			raise_error = 1'b1;
		end else if (rem_dec != 2'd0) begin
			point_nx           = joined;
			bytes_remaining_nx = rem_dec;
			raise_error        = last;
		end else begin
			point_nx           = '0;
			bytes_remaining_nx = '0;
			length_class_nx    = '0;
			raise_error        = bad_point;
			emit_point         = !bad_point;
			emit_value         = joined;
		end
		if (raise_error) begin
			point_nx           = '0;
			bytes_remaining_nx = '0;
			length_class_nx    = '0;
			discarding_nx      = !last;
			emit_point         = 1'b0;
		end
	end

	assign ev_valid      = take && (raise_error || emit_point);
	assign ev.is_error   = raise_error;
	assign ev.string_end = last;
	assign ev.point      = raise_error ? 21'd0 : emit_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_accum_q     <= '0;
			bytes_remaining_q <= '0;
			length_class_q    <= '0;
			discarding_q      <= 1'b0;
		end else if (take) begin
			point_accum_q     <= point_nx;
			bytes_remaining_q <= bytes_remaining_nx;
			length_class_q    <= length_class_nx;
			discarding_q      <= discarding_nx;
		end
	end

endmodule

// ===== hdl/u8u16_queue.sv =====
// Short first-in first-out queue of decoded events between the front and back ends of the
// UTF-8 to UTF-16 decoder unit. Depends on u8u16_pkg.
module u8u16_queue #(
	parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8u16_pkg::event_t push_ev,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output u8u16_pkg::event_t head
);
	import u8u16_pkg::*;

	// DEPTH must be a power of two of at least two, so the pointers wrap on their own; the block does not enforce it.
	localparam int unsigned AW = $clog2(DEPTH);

	event_t          slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/u8u16_back.sv =====
// Back end of the UTF-8 to UTF-16 decoder unit: turns queued events into UTF-16 results
// through an output register, splitting supplementary points into surrogate pairs.
// Depends on u8u16_pkg.
module u8u16_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ev_present,
	input  u8u16_pkg::event_t   ev,
	output logic                ev_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output u8u16_pkg::out_item_t out_data
);
	import u8u16_pkg::*;

	logic        valid_q;
	out_item_t   result_q;
	logic        low_pending_q;
	logic [15:0] low_unit_q;
	logic        low_end_q;

	logic        load;
	logic [20:0] offset;
	logic        is_supp;

	assign load    = !valid_q || out_ready;
	assign ev_pop  = load && !low_pending_q && ev_present;
	assign offset  = ev.point - SUPP_BASE;
	assign is_supp = (ev.point > BMP_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			low_pending_q <= 1'b0;
		end else if (load) begin
			if (low_pending_q) begin
				valid_q       <= 1'b1;
				low_pending_q <= 1'b0;
			end else begin
				valid_q       <= ev_present;
				low_pending_q <= ev_present && !ev.is_error && is_supp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (low_pending_q) begin
				result_q.code_unit  <= low_unit_q;
				result_q.is_error   <= 1'b0;
				result_q.run_last   <= 1'b1;
				result_q.string_end <= low_end_q;
			end else begin
				result_q.is_error   <= ev.is_error;
				result_q.string_end <= ev.string_end;
				if (ev.is_error) begin
					result_q.code_unit <= '0;
					result_q.run_last  <= 1'b1;
				end else if (is_supp) begin
					result_q.code_unit <= HIGH_SURR_BASE | {6'd0, offset[19:10]};
					result_q.run_last  <= 1'b0;
				end else begin
					result_q.code_unit <= ev.point[15:0];
					result_q.run_last  <= 1'b1;
				end
				low_unit_q <= LOW_SURR_BASE | {6'd0, offset[9:0]};
				low_end_q  <= ev.string_end;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = result_q;

endmodule

// ===== hdl/utf8_to_utf16_decoder_unit.sv =====
// Top level of the validating UTF-8 to UTF-16 decoder unit.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
// The unit takes one UTF-8 byte per transaction on the input channel and gives UTF-16
// code units on the output channel. Input is accepted at one byte per clock cycle while
// the event queue has room; a byte that completes a character in the Basic Multilingual
// Plane yields one result, a four-byte character yields a high surrogate and then a low
// surrogate with no other result between them, and continuation bytes that do not finish
// a character yield nothing. While the receiver is ready, the output register sets the
// sustained rate of one result per cycle. No byte yields more than one queued event and a
// surrogate pair needs four bytes, so bytes flow at one per cycle for as long as the
// receiver keeps taking results; the input stalls only once the receiver has held off
// long enough to fill the output register and the QUEUE_DEPTH entries of the event queue,
// and while the queue is full it takes no byte even in a cycle in which an event leaves
// it. A result passes the event queue and the output register, so it cannot be taken at
// the edge at which its byte is accepted. On the first malformed byte, truncated sequence,
// overlong form, surrogate value or value above U+10FFFF in a string, the unit reports a
// single error result with a zero code unit; it then drops the rest of that string
// silently and is ready for a new string after the byte that carries string_last. Every
// result copies string_last of the byte that caused it, and run_last marks the final
// result of that byte.
module utf8_to_utf16_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  u8u16_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u8u16_pkg::out_item_t out_data
);
	import u8u16_pkg::*;

	// The front end classifies bytes and keeps the sequence state; it may run on as long
	// as the queue has room, independent of whether the output side is stalled.
	logic   take;
	logic   ev_valid;
	event_t ev_front;
	logic   queue_full;
	logic   queue_empty;
	event_t queue_head;
	logic   ev_pop;

	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready;

	u8u16_front front_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (in_data),
		.ev_valid (ev_valid),
		.ev       (ev_front)
	);

	// Decoded events wait here, so a stalled consumer does not stop byte intake at once.
	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) queue_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (ev_valid),
		.push_ev (ev_front),
		.pop     (ev_pop),
		.full    (queue_full),
		.empty   (queue_empty),
		.head    (queue_head)
	);

	// The back end owns the output register and splits supplementary points into pairs.
	u8u16_back back_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev_present (!queue_empty),
		.ev         (queue_head),
		.ev_pop     (ev_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== hdl/u8u16_checker.sv =====
// Port-level checker for the UTF-8 to UTF-16 decoder unit, bound to the top level.
// Depends on u8u16_pkg and utf8_to_utf16_decoder_unit.
module u8u16_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input u8u16_pkg::in_item_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input u8u16_pkg::out_item_t out_data
);
	import u8u16_pkg::*;

	// A byte offered but not taken is still offered, unchanged, in the next cycle.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input transaction withdrawn or changed before acceptance");

	// A result offered but not taken is still offered in the next cycle.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction withdrawn before acceptance");

	// An error result carries a zero code unit and closes its byte's results.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_error |-> out_data.code_unit == 16'd0 && out_data.run_last)
		else $error("malformed error result");

	// A result that is not the last of its byte is a high surrogate.
	a_high_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.run_last |->
			out_data.code_unit[15:10] == 6'b110110 && !out_data.is_error)
		else $error("first result of a pair is not a high surrogate");

	// Once a high surrogate is taken, its low surrogate follows in the next cycle.
	a_low_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.run_last |=>
			out_valid && out_data.run_last && out_data.code_unit[15:10] == 6'b110111 &&
			out_data.string_end == $past(out_data.string_end))
		else $error("low surrogate missing after high surrogate");

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker checker_i (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== sim/utf8_to_utf16_decoder_checker.sv =====
// Scoreboard for the UTF-8 to UTF-16 decoder unit: watches both channels, predicts results.
// Depends on u8u16_pkg for the payload structs and the code point limits.
module utf8_to_utf16_decoder_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  u8u16_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  u8u16_pkg::out_item_t out_data,
	output int                   fail_count,
	output int                   units_outstanding,
	output int                   results_checked,
	output int                   error_results,
	output int                   pair_count
);
	import u8u16_pkg::*;

	localparam int PRINT_LIMIT = 30;

	// Decoder state as the predictor sees it.
	logic [20:0] seq_point;
	logic [1:0]  seq_left;
	logic [1:0]  seq_class;
	logic        dropping;

	out_item_t   units_due[$];

	initial begin
		fail_count = 0;
		results_checked = 0;
		error_results = 0;
		pair_count = 0;
		units_outstanding = 0;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic clear_sequence();
		seq_point = '0;
		seq_left = '0;
		seq_class = '0;
	endtask

	// Appends one expected result at the tail of the list.
	task automatic queue_unit(input logic [15:0] unit, input logic err, input logic rl,
		input logic se);
		out_item_t item;
		item.code_unit = unit;
		item.is_error = err;
		item.run_last = rl;
		item.string_end = se;
		units_due.insert(units_due.size(), item);
	endtask

	task automatic flag_error(input logic lst);
		clear_sequence();
		dropping = !lst;
		queue_unit(16'h0000, 1'b1, 1'b1, lst);
	endtask

	task automatic emit_point(input logic [20:0] cp, input logic lst);
		logic [20:0] offset;
		if (cp <= BMP_LAST) begin
			queue_unit(cp[15:0], 1'b0, 1'b1, lst);
		end else begin
			offset = cp - SUPP_BASE;
			queue_unit(HIGH_SURR_BASE + {6'd0, offset[19:10]}, 1'b0, 1'b0, lst);
			queue_unit(LOW_SURR_BASE + {6'd0, offset[9:0]}, 1'b0, 1'b1, lst);
		end
	endtask

	task automatic predict_byte(input in_item_t item);
		logic [7:0]  b;
		logic        lst;
		logic [20:0] cp;
		logic [20:0] floor_point;
		b = item.data_byte;
		lst = item.string_last;
		if (dropping) begin
			if (lst) begin
				dropping = 1'b0;
				clear_sequence();
			end
			return;
		end
		if (seq_left == 2'd0) begin
			if (!b[7]) begin
				emit_point({13'd0, b}, lst);
				return;
			end
			if (b[7:5] == 3'b110) begin
				seq_point = {16'd0, b[4:0]};
				seq_left = 2'd1;
				seq_class = LEN_TWO;
			end else if (b[7:4] == 4'b1110) begin
				seq_point = {17'd0, b[3:0]};
				seq_left = 2'd2;
				seq_class = LEN_THREE;
			end else if (b[7:3] == 5'b11110) begin
				seq_point = {18'd0, b[2:0]};
				seq_left = 2'd3;
				seq_class = LEN_FOUR;
			end else begin
				flag_error(lst);
				return;
			end
			if (lst)
				flag_error(lst);
			return;
		end
		if (b[7:6] != 2'b10) begin
			flag_error(lst);
			return;
		end
		seq_point = {seq_point[14:0], b[5:0]};
		seq_left = seq_left - 2'd1;
		if (seq_left != 2'd0) begin
			if (lst)
				flag_error(lst);
			return;
		end
		cp = seq_point;
		case (seq_class)
			LEN_TWO:   floor_point = MIN_TWO_BYTE;
			LEN_THREE: floor_point = MIN_THREE_BYTE;
			default:   floor_point = SUPP_BASE;
		endcase
		clear_sequence();
		if (cp < floor_point || cp > MAX_POINT || (cp >= SURR_FIRST && cp <= SURR_LAST))
			flag_error(lst);
		else
			emit_point(cp, lst);
	endtask

	task automatic check_unit(input out_item_t got);
		out_item_t want;
		if (units_due.size() == 0) begin
			report_mismatch($sformatf("result %h arrived with nothing expected", got));
			return;
		end
		want = units_due.pop_front();
		if (got.code_unit != want.code_unit)
			report_mismatch($sformatf("code_unit %h, expected %h", got.code_unit,
				want.code_unit));
		if (got.is_error != want.is_error)
			report_mismatch($sformatf("is_error %b, expected %b", got.is_error,
				want.is_error));
		if (got.run_last != want.run_last)
			report_mismatch($sformatf("run_last %b, expected %b", got.run_last,
				want.run_last));
		if (got.string_end != want.string_end)
			report_mismatch($sformatf("string_end %b, expected %b", got.string_end,
				want.string_end));
		results_checked++;
		if (want.is_error)
			error_results++;
		if (!want.run_last)
			pair_count++;
	endtask

	// Results are checked before the byte of the same edge is predicted; a byte cannot
	// produce a result on the edge at which it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sequence();
			dropping = 1'b0;
			units_due.delete();
			units_outstanding <= 0;
		end else begin
			if (out_valid && out_ready)
				check_unit(out_data);
			if (in_valid && in_ready)
				predict_byte(in_data);
			units_outstanding <= units_due.size();
		end
	end

endmodule

// ===== sim/utf8_to_utf16_decoder_unit_tb.sv =====
// Testbench top for the UTF-8 to UTF-16 decoder unit: clock, reset, byte stimulus,
// receiver back-pressure and the verdict. Depends on u8u16_pkg, the unit and its checker.
module utf8_to_utf16_decoder_unit_tb;
	import u8u16_pkg::*;

	localparam int RANDOM_TARGET  = 1030;
	localparam int SQUEEZE_AT     = 500;
	localparam int SQUEEZE_CYCLES = 250;
	localparam int DRAIN_CYCLES   = 20;

	// Directed bytes: bit 8 is string_last, bits 7:0 the byte itself.
	localparam logic [8:0] DIRECTED [29] = '{
		9'h000, 9'h17F,                                  // ASCII extremes
		9'h0C2, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF,          // U+0080 and U+FFFF
		9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,                  // U+10FFFF, a surrogate pair
		9'h080, 9'h041, 9'h142,                          // stray continuation, then dropped
		9'h0C0, 9'h180,                                  // overlong lead C0
		9'h0ED, 9'h0A0, 9'h180,                          // encoded surrogate
		9'h0F5, 9'h080, 9'h080, 9'h180,                  // lead F5, above U+10FFFF
		9'h0C2, 9'h141,                                  // bad continuation at string end
		9'h1E2,                                          // string ends on a lead
		9'h0E2, 9'h182,                                  // string ends mid-sequence
		9'h1FF                                           // invalid lead at string end
	};

	// Ways in which the random stimulus breaks a character.
	typedef enum int {
		FAULT_BAD_LEAD,
		FAULT_OVERLONG,
		FAULT_SURROGATE,
		FAULT_TOO_BIG,
		FAULT_BAD_CONT,
		FAULT_TRUNCATED,
		FAULT_ANY_BYTE
	} fault_kind_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;

	int         fail_count;
	int         units_outstanding;
	int         results_checked;
	int         error_results;
	int         pair_count;

	int         bytes_sent;
	int         strings_sent;
	bit         squeeze_now;
	logic [7:0] string_bytes[$];

	utf8_to_utf16_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	utf8_to_utf16_decoder_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.in_data           (in_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_data          (out_data),
		.fail_count        (fail_count),
		.units_outstanding (units_outstanding),
		.results_checked   (results_checked),
		.error_results     (error_results),
		.pair_count        (pair_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the unit deadlocks.
	initial begin
		#10_000_000;
		$display("Timeout: the run did not drain in time.");
		$display("Regression FAIL");
		$finish;
	end

	// Idle lengths: mostly from the shortest range, sometimes longer, now and then a long pause.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		if (roll < 93)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Appends one byte at the end of the string buffer.
	task automatic add_byte(input logic [7:0] value);
		string_bytes.insert(string_bytes.size(), value);
	endtask

	// Writes a code point into the string buffer with the given sequence length. Points
	// that do not fit are cut to the available payload bits; overlong and out-of-range
	// forms come from short points with a long length and from points above U+10FFFF.
	task automatic add_encoded(input logic [20:0] cp, input int nbytes);
		case (nbytes)
			1: add_byte({1'b0, cp[6:0]});
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// A legal code point for the given length, with a bias towards the range boundaries.
	function automatic logic [20:0] pick_point(input int nbytes);
		logic [20:0] lo;
		logic [20:0] hi;
		logic [20:0] cp;
		case (nbytes)
			1:       begin lo = 21'h0;          hi = 21'h7F;                   end
			2:       begin lo = MIN_TWO_BYTE;   hi = MIN_THREE_BYTE - 21'd1;   end
			3:       begin lo = MIN_THREE_BYTE; hi = BMP_LAST;                 end
			default: begin lo = SUPP_BASE;      hi = MAX_POINT;                end
		endcase
		case ($urandom_range(0, 9))
			0:       cp = lo;
			1:       cp = hi;
			default: cp = 21'($urandom_range(lo, hi));
		endcase
		// Move random picks out of the surrogate block; D000..D7FF are ordinary points.
		if (cp >= SURR_FIRST && cp <= SURR_LAST)
			cp = cp - 21'h800;
		return cp;
	endfunction

	// Appends one broken character. Returns ends_here when the string must stop at once,
	// which is how sequences cut short by string_last are made.
	task automatic add_fault(output bit ends_here);
		fault_kind_t kind;
		int          nbytes;
		int          pos;
		logic [20:0] cp;
		ends_here = 1'b0;
		kind = fault_kind_t'($urandom_range(0, 6));
		nbytes = $urandom_range(2, 4);
		case (kind)
			FAULT_BAD_LEAD: begin
				if ($urandom_range(0, 1))
					add_byte(8'($urandom_range(8'h80, 8'hBF)));
				else
					add_byte(8'($urandom_range(8'hF8, 8'hFF)));
			end
			FAULT_OVERLONG: begin
				case (nbytes)
					2:       cp = 21'($urandom_range(0, MIN_TWO_BYTE - 21'd1));
					3:       cp = 21'($urandom_range(0, MIN_THREE_BYTE - 21'd1));
					default: cp = 21'($urandom_range(0, SUPP_BASE - 21'd1));
				endcase
				add_encoded(cp, nbytes);
			end
			FAULT_SURROGATE: add_encoded(21'($urandom_range(SURR_FIRST, SURR_LAST)), 3);
			FAULT_TOO_BIG:   add_encoded(21'($urandom_range(MAX_POINT + 21'd1, 21'h1FFFFF)),
				4);
			FAULT_BAD_CONT: begin
				add_encoded(pick_point(nbytes), nbytes);
				pos = string_bytes.size() - $urandom_range(1, nbytes - 1);
				if ($urandom_range(0, 1))
					string_bytes[pos] = 8'($urandom_range(8'h00, 8'h7F));
				else
					string_bytes[pos] = 8'($urandom_range(8'hC0, 8'hFF));
			end
			FAULT_TRUNCATED: begin
				add_encoded(pick_point(nbytes), nbytes);
				repeat ($urandom_range(1, nbytes - 1))
					void'(string_bytes.pop_back());
				ends_here = 1'b1;
			end
			default: add_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	// Builds one string: mostly well-formed characters of random length and content,
	// with roughly one character in seven broken.
	task automatic build_string();
		int chars;
		int nbytes;
		bit ends_here;
		string_bytes.delete();
		chars = $urandom_range(1, 8);
		for (int i = 0; i < chars; i++) begin
			if ($urandom_range(0, 99) < 86) begin
				nbytes = $urandom_range(1, 4);
				add_encoded(pick_point(nbytes), nbytes);
			end else begin
				add_fault(ends_here);
				if (ends_here)
					break;
			end
		end
	endtask

	// Offers one byte and holds it until the unit takes it, then sometimes idles for a while
	// unless the caller wants back-to-back transactions.
	task automatic send_byte(input logic [7:0] value, input logic is_last, input bit no_gaps);
		int gap;
		in_data <= '{data_byte: value, string_last: is_last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		gap = 0;
		if (!no_gaps && $urandom_range(0, 99) >= 55)
			gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_string(input bit no_gaps);
		for (int i = 0; i < string_bytes.size(); i++)
			send_byte(string_bytes[i], i == string_bytes.size() - 1, no_gaps);
		strings_sent++;
	endtask

	// Byte source: reset, the directed strings, then random strings with one long
	// receiver hold-off in the middle, then drain and give the verdict.
	initial begin
		bit squeezed;
		squeezed = 1'b0;
		bytes_sent = 0;
		strings_sent = 0;
		squeeze_now = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);
			if (DIRECTED[i][8])
				strings_sent++;
		end

		while (bytes_sent < RANDOM_TARGET) begin
			if (!squeezed && bytes_sent >= SQUEEZE_AT) begin
				// The receiver stops taking results while a long string of surrogate pairs
				// and ASCII is offered without gaps, so the event queue fills and the unit
				// has to hold its input off.
				squeezed = 1'b1;
				squeeze_now = 1'b1;
				string_bytes.delete();
				for (int i = 0; i < 40; i++)
					add_encoded(pick_point(i % 2 == 0 ? 4 : 1), i % 2 == 0 ? 4 : 1);
				send_string(1'b1);
			end else begin
				build_string();
				send_string($urandom_range(0, 99) < 15);
			end
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (units_outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d strings; checked %0d results (%0d errors, %0d pairs).",
			bytes_sent, strings_sent, results_checked, error_results, pair_count);
		$display("The receiver held off for %0d cycles once while bytes kept coming.",
			SQUEEZE_CYCLES);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Result sink: random short stalls, occasional long ones, some stretches of constant
	// readiness, and one long hold-off when the byte source asks for it.
	initial begin
		int hold;
		int unbroken;
		hold = 0;
		unbroken = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_now) begin
				squeeze_now = 1'b0;
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (unbroken > 0)
					unbroken--;
				else if ($urandom_range(0, 99) < 25)
					hold = idle_len();
				else if ($urandom_range(0, 99) < 3)
					unbroken = $urandom_range(20, 80);
			end
		end
	end

endmodule

// ===== utf8_to_utf16_decoder_unit.f =====
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_queue.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_decoder_unit.sv
hdl/u8u16_checker.sv
sim/utf8_to_utf16_decoder_checker.sv
sim/utf8_to_utf16_decoder_unit_tb.sv
